// File: hw/rtl/wma3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wma3_pkg
// shared widths, constants and types of the three-axis weighted moving average
// ----------------------------------------------------------------------------
package wma3_pkg;

	localparam int WINDOW         = 40;
	localparam int SAMPLE_BITS    = 16;
	localparam int AXES           = 3;
	localparam int WEIGHT_DIVISOR = WINDOW * (WINDOW + 1) / 2;

	localparam int SLOT_BITS    = $clog2(WINDOW);
	localparam int PLAIN_BITS   = SAMPLE_BITS + $clog2(WINDOW);
	localparam int WGT_BITS     = SAMPLE_BITS + $clog2(WEIGHT_DIVISOR) + 1;

	// stream widths, payload padded to whole bytes
	localparam int DATA_BITS    = AXES * SAMPLE_BITS;
	localparam int TDATA_BITS   = ((DATA_BITS + 7) / 8) * 8;

	// exact division by the total weight through a reciprocal
	localparam int MAG_BITS     = WGT_BITS - 1;
	localparam int DIV_SHIFT    = MAG_BITS + $clog2(WEIGHT_DIVISOR);
	localparam int RECIP_BITS   = MAG_BITS + 1;
	localparam int PROD_BITS    = MAG_BITS + RECIP_BITS;
	localparam logic [RECIP_BITS-1:0] RECIP =
		RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'(WEIGHT_DIVISOR) - 64'd1) / 64'(WEIGHT_DIVISOR));

	localparam logic signed [WGT_BITS-1:0] WINDOW_WGT = WGT_BITS'(WINDOW);
	localparam logic [SLOT_BITS-1:0]       LAST_SLOT  = SLOT_BITS'(WINDOW - 1);

	typedef logic [AXES-1:0][SAMPLE_BITS-1:0] triple_t;

	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} pipe_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/weighted_moving_average_3axis.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_moving_average_3axis
// linearly weighted moving average of three-axis samples over a 40-item ring
// ----------------------------------------------------------------------------
// pipeline: a result item becomes valid on the master side once its input item
//   has passed the sum, product and result stages
// throughput: one item per cycle unless the master side stalls, set by the
//   running-sum update and the one-write one-read port of the sample ring
// reset: arst_n clears the sums, write slot, ring fill flag and stage valids;
//   ring entries not yet written since reset count as zero samples
// ----------------------------------------------------------------------------
module weighted_moving_average_3axis (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// slave side: sample_x, sample_y, sample_z (lowest bits first)
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [wma3_pkg::TDATA_BITS-1:0]    s_axis_tdata,
	// master side: average_x, average_y, average_z (lowest bits first)
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [wma3_pkg::TDATA_BITS-1:0]         m_axis_tdata
);

	wma3_pkg::pipe_ctrl_t ctrl;
	wma3_pkg::triple_t    sample;
	wma3_pkg::triple_t    oldest;
	wma3_pkg::triple_t    average;
	logic                 accept;
	logic                 v_s1;
	logic                 v_s2;
	logic                 v_s3;

	// stage 1 holds the running sums themselves, stage 2 the reciprocal
	// product, stage 3 the result item on the master side
	assign ctrl.load_s3 = !v_s3 || m_axis_tready;
	assign ctrl.load_s2 = !v_s2 || ctrl.load_s3;
	assign s_axis_tready = !v_s1 || ctrl.load_s2;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
			if (ctrl.load_s2) begin
				v_s2 <= v_s1;
			end
			if (ctrl.load_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// bits above the three fields are ignored
	assign sample = s_axis_tdata[wma3_pkg::DATA_BITS-1:0];

	// ring gives the sample that the accepted item pushes out
	wma3_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.oldest (oldest)
	);

	for (genvar a = 0; a < wma3_pkg::AXES; a++) begin : g_axis
		logic signed [wma3_pkg::WGT_BITS-1:0] weighted;

		wma3_sums u_sums (
			.clk      (clk),
			.arst_n   (arst_n),
			.accept   (accept),
			.fresh    ($signed(sample[a])),
			.oldest   ($signed(oldest[a])),
			.weighted (weighted)
		);

		wma3_div u_div (
			.clk      (clk),
			.ctrl     (ctrl),
			.weighted (weighted),
			.average  (average[a])
		);
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = wma3_pkg::TDATA_BITS'(average);

	// an empty first stage never holds off the slave side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_axis_tready)
		else $error("input stalled with an empty first stage");

	// input only stalls when every stage is full and the result is not taken
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && v_s3 && !m_axis_tready))
		else $error("input stalled with room in the pipeline");

	// an accepted item occupies the first stage next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted item lost before first stage");

	// an item moving out of stage 2 shows up as a result
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && ctrl.load_s3) |=> m_axis_tvalid)
		else $error("item lost between product and result stage");

endmodule
`default_nettype wire

// File: hw/rtl/wma3_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wma3_ring
// sample ring with write slot and prefetched read of the oldest entry
// ----------------------------------------------------------------------------
module wma3_ring (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire wma3_pkg::triple_t sample,
	output wma3_pkg::triple_t      oldest
);

	wma3_pkg::triple_t                  ring_mem [wma3_pkg::WINDOW];
	wma3_pkg::triple_t                  rd_q;
	logic [wma3_pkg::SLOT_BITS-1:0]     slot_q;
	logic [wma3_pkg::SLOT_BITS-1:0]     next_slot;
	logic [wma3_pkg::SLOT_BITS-1:0]     rd_addr;
	logic                               wrapped_q;

	assign next_slot = (slot_q == wma3_pkg::LAST_SLOT) ? '0 : slot_q + 1'b1;
	// read ahead the slot the next item will overwrite
	assign rd_addr   = accept ? next_slot : slot_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			ring_mem[slot_q] <= sample;
		end
		rd_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
		end else if (accept) begin
			slot_q <= next_slot;
			if (slot_q == wma3_pkg::LAST_SLOT) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	// slots not yet written since reset read as zero
	assign oldest = wrapped_q ? rd_q : '0;

endmodule
`default_nettype wire

// File: hw/rtl/wma3_sums.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wma3_sums
// recursive plain and weighted running sums of one axis
// ----------------------------------------------------------------------------
module wma3_sums (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  accept,
	input  wire logic signed [wma3_pkg::SAMPLE_BITS-1:0] fresh,
	input  wire logic signed [wma3_pkg::SAMPLE_BITS-1:0] oldest,
	output logic signed [wma3_pkg::WGT_BITS-1:0]       weighted
);

	logic signed [wma3_pkg::WGT_BITS-1:0]   weighted_q;
	logic signed [wma3_pkg::PLAIN_BITS-1:0] plain_q;
	logic signed [wma3_pkg::WGT_BITS-1:0]   fresh_w;
	logic signed [wma3_pkg::WGT_BITS-1:0]   plain_w;
	logic signed [wma3_pkg::WGT_BITS-1:0]   weighted_next;
	logic signed [wma3_pkg::PLAIN_BITS-1:0] plain_next;

	assign fresh_w = wma3_pkg::WGT_BITS'(fresh);
	assign plain_w = wma3_pkg::WGT_BITS'(plain_q);

	// every stored sample drops one weight, the new one enters at full weight
	assign weighted_next = weighted_q + fresh_w * wma3_pkg::WINDOW_WGT - plain_w;
	assign plain_next    = plain_q + wma3_pkg::PLAIN_BITS'(fresh)
	                     - wma3_pkg::PLAIN_BITS'(oldest);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_q <= '0;
			plain_q    <= '0;
		end else if (accept) begin
			weighted_q <= weighted_next;
			plain_q    <= plain_next;
		end
	end

	assign weighted = weighted_q;

endmodule
`default_nettype wire

// File: hw/rtl/wma3_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wma3_div
// two-stage division of a weighted sum by the total weight, toward zero
// ----------------------------------------------------------------------------
module wma3_div (
	input  wire logic                                  clk,
	input  wire wma3_pkg::pipe_ctrl_t                  ctrl,
	input  wire logic signed [wma3_pkg::WGT_BITS-1:0]  weighted,
	output logic [wma3_pkg::SAMPLE_BITS-1:0]           average
);

	logic [wma3_pkg::MAG_BITS-1:0]    mag;
	logic [wma3_pkg::PROD_BITS-1:0]   prod_s2;
	logic                             neg_s2;
	logic [wma3_pkg::SAMPLE_BITS-1:0] quot;
	logic [wma3_pkg::SAMPLE_BITS-1:0] avg_s3;

	assign mag = weighted[wma3_pkg::WGT_BITS-1]
	           ? wma3_pkg::MAG_BITS'(-weighted)
	           : wma3_pkg::MAG_BITS'(weighted);

	// reciprocal is rounded up so the shifted product is the exact floor
	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			prod_s2 <= wma3_pkg::PROD_BITS'(mag) * wma3_pkg::PROD_BITS'(wma3_pkg::RECIP);
			neg_s2  <= weighted[wma3_pkg::WGT_BITS-1];
		end
	end

	assign quot = wma3_pkg::SAMPLE_BITS'(prod_s2 >> wma3_pkg::DIV_SHIFT);

	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			avg_s3 <= neg_s2 ? -quot : quot;
		end
	end

	assign average = avg_s3;

endmodule
`default_nettype wire

// File: sim/tb_weighted_moving_average_3axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_moving_average_3axis
// stream-level check of the three-axis linearly weighted moving average
// ----------------------------------------------------------------------------
// every accepted sample is folded into a local running-sum predictor and its
// expected averages are queued; each result that leaves the master side is
// compared axis by axis with the oldest entry of that queue. the sender works
// in bursts with random gaps, the receiver stalls in phases of its own, and
// the stream is paused once until all pending averages have drained
// ----------------------------------------------------------------------------
module tb_weighted_moving_average_3axis;

	localparam int  IDLE_LIMIT = 1000;  // cycles without any handshake
	localparam int  DRAIN_TAIL = 20;    // settle time after the last average
	localparam int  SMAX       = (1 << (wma3_pkg::SAMPLE_BITS - 1)) - 1;
	localparam int  SMIN       = -(1 << (wma3_pkg::SAMPLE_BITS - 1));
	localparam string AXIS_NAMES [wma3_pkg::AXES] = '{"x", "y", "z"};

	// receiver behaviour, selected by the top two bits of rx_phase
	typedef enum logic [1:0] {
		RX_OPEN,      // always ready
		RX_LIGHT,     // ready with a chance of three in four, at random
		RX_HEAVY,     // ready with a chance of one in four, at random
		RX_PERIODIC   // fixed pattern, stalled whenever the low two phase bits are zero
	} rx_mode_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [wma3_pkg::TDATA_BITS-1:0] s_axis_tdata = '0;  // sample_x, sample_y, sample_z
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [wma3_pkg::TDATA_BITS-1:0] m_axis_tdata;       // average_x, average_y, average_z

	// predictor state: the sample window and its two running sums per axis
	logic signed [wma3_pkg::SAMPLE_BITS-1:0] window_samples [wma3_pkg::WINDOW][wma3_pkg::AXES];
	longint                        window_sum [wma3_pkg::AXES];
	longint                        window_weighted_sum [wma3_pkg::AXES];
	int                            oldest_slot;

	wma3_pkg::triple_t expected_averages [$];
	int      mismatch_count = 0;
	int      idle_cycles = 0;
	int      burst_left = 0;
	int      walk_pos [wma3_pkg::AXES];
	logic [8:0] rx_phase = '0;

	weighted_moving_average_3axis DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// window after reset: all zero samples, zero sums, oldest slot at zero
	function automatic void clear_window();
		for (int i = 0; i < wma3_pkg::WINDOW; i++)
			for (int a = 0; a < wma3_pkg::AXES; a++)
				window_samples[i][a] = '0;
		for (int a = 0; a < wma3_pkg::AXES; a++) begin
			window_sum[a]          = 0;
			window_weighted_sum[a] = 0;
		end
		oldest_slot = 0;
	endfunction

	// push one sample into the window and return the weighted averages;
	// every older sample loses one weight, the new one enters with WINDOW
	function automatic wma3_pkg::triple_t advance_average(wma3_pkg::triple_t sample);
		wma3_pkg::triple_t avg;
		longint  fresh;
		longint  quot;
		for (int a = 0; a < wma3_pkg::AXES; a++) begin
			fresh = longint'($signed(sample[a]));
			window_weighted_sum[a] = window_weighted_sum[a] + wma3_pkg::WINDOW * fresh
			                       - window_sum[a];
			window_sum[a] = window_sum[a] + fresh - longint'(window_samples[oldest_slot][a]);
			window_samples[oldest_slot][a] = sample[a];
			// signed division truncates toward zero, as the block must
			quot   = window_weighted_sum[a] / wma3_pkg::WEIGHT_DIVISOR;
			avg[a] = quot[wma3_pkg::SAMPLE_BITS-1:0];
		end
		oldest_slot = (oldest_slot == wma3_pkg::WINDOW - 1) ? 0 : oldest_slot + 1;
		return avg;
	endfunction

	// ------------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------------

	// one item on the slave side; between bursts tvalid drops for a random gap,
	// and a gap of zero keeps the stream dense across the burst boundary
	task automatic send_sample(input wma3_pkg::triple_t sample);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= wma3_pkg::TDATA_BITS'(sample);
		do @(posedge clk); while (!s_axis_tready);
		expected_averages.push_back(advance_average(sample));
	endtask

	// lower tvalid at the edge of the last handshake and let the stream run dry
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_averages.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// receiver: stall pattern, checker and watchdog
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		rx_phase <= rx_phase + 1'b1;
		case (rx_mode_t'(rx_phase[8:7]))
			RX_OPEN:     m_axis_tready <= 1'b1;
			RX_LIGHT:    m_axis_tready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY:    m_axis_tready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: m_axis_tready <= (rx_phase[1:0] != 2'd0);
			default:     m_axis_tready <= 1'b1;
		endcase
	end

	// every average leaving the block is matched against the oldest expectation
	always @(posedge clk) begin
		wma3_pkg::triple_t want;
		wma3_pkg::triple_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[wma3_pkg::AXES*wma3_pkg::SAMPLE_BITS-1:0];
			if (expected_averages.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected average item %h", $time, got);
			end else begin
				want = expected_averages.pop_front();
				for (int a = 0; a < wma3_pkg::AXES; a++) begin
					if (got[a] !== want[a]) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: average_%s expected %0d, got %0d", $time,
								AXIS_NAMES[a], $signed(want[a]), $signed(got[a]));
					end
				end
			end
		end
	end

	// cycles in which no item moves on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("weighted_moving_average_3axis: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	task automatic run_reset();
		clear_window();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// field extremes and bit patterns while the window is still mostly empty,
	// so unwritten slots act as zero samples; small negative samples check
	// truncation toward zero rather than flooring
	task automatic test_directed_extremes();
		send_sample({16'sd0, 16'sd0, 16'sd0});
		send_sample({wma3_pkg::SAMPLE_BITS'(SMAX), wma3_pkg::SAMPLE_BITS'(SMAX),
			wma3_pkg::SAMPLE_BITS'(SMAX)});
		send_sample({wma3_pkg::SAMPLE_BITS'(SMIN), wma3_pkg::SAMPLE_BITS'(SMIN),
			wma3_pkg::SAMPLE_BITS'(SMIN)});
		send_sample({16'sd0, wma3_pkg::SAMPLE_BITS'(SMIN), wma3_pkg::SAMPLE_BITS'(SMAX)});
		send_sample({wma3_pkg::SAMPLE_BITS'(SMAX), 16'sd0, wma3_pkg::SAMPLE_BITS'(SMIN)});
		send_sample({-16'sd1, 16'sd1, -16'sd1});
		send_sample({16'sd1, -16'sd1, 16'sd1});
		send_sample({-16'sd2, 16'sd2, -16'sd3});
		send_sample({16'h5555, 16'haaaa, 16'h5555});
		send_sample({16'haaaa, 16'h5555, 16'haaaa});
		send_sample({16'h8001, 16'h7ffe, 16'hfffe});
		send_sample({16'h0001, 16'h8000, 16'h7fff});
	endtask

	// fill the whole window and wrap round it with constant extremes, which
	// must settle on exactly full-scale averages
	task automatic test_full_scale_window();
		repeat (wma3_pkg::WINDOW + 5)
			send_sample({wma3_pkg::SAMPLE_BITS'(SMAX), wma3_pkg::SAMPLE_BITS'(SMIN),
				wma3_pkg::SAMPLE_BITS'(SMAX)});
		repeat (wma3_pkg::WINDOW + 5)
			send_sample({wma3_pkg::SAMPLE_BITS'(SMIN), wma3_pkg::SAMPLE_BITS'(SMAX),
				wma3_pkg::SAMPLE_BITS'(SMIN)});
	endtask

	// mix of uniform noise, extreme values and slowly drifting sensor-like data
	task automatic test_random_stream(input int count);
		wma3_pkg::triple_t sample;
		int      kind;
		for (int a = 0; a < wma3_pkg::AXES; a++) walk_pos[a] = 0;
		repeat (count) begin
			kind = $urandom_range(0, 9);
			for (int a = 0; a < wma3_pkg::AXES; a++) begin
				if (kind < 5) begin
					sample[a] = wma3_pkg::SAMPLE_BITS'($urandom);
				end else if (kind < 7) begin
					case ($urandom_range(0, 4))
						0:       sample[a] = wma3_pkg::SAMPLE_BITS'(SMAX);
						1:       sample[a] = wma3_pkg::SAMPLE_BITS'(SMIN);
						2:       sample[a] = '0;
						3:       sample[a] = '1;
						default: sample[a] = wma3_pkg::SAMPLE_BITS'(1);
					endcase
				end else begin
					walk_pos[a] += $urandom_range(0, 512) - 256;
					if (walk_pos[a] > SMAX) walk_pos[a] = SMAX;
					if (walk_pos[a] < SMIN) walk_pos[a] = SMIN;
					sample[a] = wma3_pkg::SAMPLE_BITS'(walk_pos[a]);
				end
			end
			send_sample(sample);
		end
	endtask

	// stop sending until every pending average has come out, then resume
	task automatic test_drain_pause();
		test_random_stream(20);
		hold_until_drained();
		test_random_stream(20);
	endtask

	initial begin
		run_reset();
		test_directed_extremes();
		test_full_scale_window();
		test_random_stream(480);
		test_drain_pause();
		hold_until_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0)
			$display("weighted_moving_average_3axis: match");
		else
			$display("weighted_moving_average_3axis: mismatch");
		$finish;
	end

endmodule
